@@ src/dpss_pkg.sv @@
// ----------------------------------------------------------------------------
// dpss_pkg
// Shared types and constants for the drive power state sequencer.
// ----------------------------------------------------------------------------
package dpss_pkg;

    localparam int unsigned WordW  = 16;
    localparam int unsigned LimitW = 8;

    localparam logic [LimitW-1:0] AttemptLimitReset = 8'd10;

    // statusword masks and match patterns
    localparam logic [WordW-1:0] SwMaskA       = 16'h004f;
    localparam logic [WordW-1:0] SwMaskB       = 16'h006f;
    localparam logic [WordW-1:0] SwNotReady    = 16'h0000;
    localparam logic [WordW-1:0] SwSwitchDis   = 16'h0040;
    localparam logic [WordW-1:0] SwReady       = 16'h0021;
    localparam logic [WordW-1:0] SwSwitchedOn  = 16'h0023;
    localparam logic [WordW-1:0] SwEnabled     = 16'h0027;
    localparam logic [WordW-1:0] SwQuickStop   = 16'h0007;
    localparam logic [WordW-1:0] SwFaultReact  = 16'h000f;
    localparam logic [WordW-1:0] SwFault       = 16'h0008;

    // controlwords
    localparam logic [WordW-1:0] CwShutdown    = 16'h0006;
    localparam logic [WordW-1:0] CwSwitchOn    = 16'h0007;
    localparam logic [WordW-1:0] CwEnableOp    = 16'h000f;
    localparam logic [WordW-1:0] CwFaultReset  = 16'h0080;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_ENABLE      = 2'd1,
        OP_DISABLE     = 2'd2,
        OP_FAULT_RESET = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        PS_NOT_READY   = 4'd0,
        PS_SWITCH_DIS  = 4'd1,
        PS_READY       = 4'd2,
        PS_SWITCHED_ON = 4'd3,
        PS_ENABLED     = 4'd4,
        PS_QUICK_STOP  = 4'd5,
        PS_FAULT_REACT = 4'd6,
        PS_FAULT       = 4'd7,
        PS_UNKNOWN     = 4'd8
    } t_pstate;

    typedef enum logic [2:0] {
        OC_IDLE      = 3'd0,
        OC_BUSY      = 3'd1,
        OC_GOAL      = 3'd2,
        OC_FAIL_LIM  = 3'd3,
        OC_FAIL_STAT = 3'd4
    } t_outcome;

    typedef struct packed {
        logic [WordW-1:0] control_word;
        t_pstate          power_state;
        t_outcome         outcome;
    } t_result;

endpackage

@@ src/dpss_decode.sv @@
// ----------------------------------------------------------------------------
// dpss_decode
// Statusword to power state decoder, masked compares, first match wins.
// ----------------------------------------------------------------------------
module dpss_decode
    import dpss_pkg::*;
(
    input  logic [WordW-1:0] i_statusword,
    output t_pstate          o_power_state
);

    logic [WordW-1:0] w_a;
    logic [WordW-1:0] w_b;

    assign w_a = i_statusword & SwMaskA;
    assign w_b = i_statusword & SwMaskB;

    always_comb begin
        priority if (w_a == SwNotReady)   o_power_state = PS_NOT_READY;
        else if (w_a == SwSwitchDis)      o_power_state = PS_SWITCH_DIS;
        else if (w_b == SwReady)          o_power_state = PS_READY;
        else if (w_b == SwSwitchedOn)     o_power_state = PS_SWITCHED_ON;
        else if (w_b == SwEnabled)        o_power_state = PS_ENABLED;
        else if (w_b == SwQuickStop)      o_power_state = PS_QUICK_STOP;
        else if (w_a == SwFaultReact)     o_power_state = PS_FAULT_REACT;
        else if (w_a == SwFault)          o_power_state = PS_FAULT;
        else                              o_power_state = PS_UNKNOWN;
    end

endmodule

@@ src/dpss_core.sv @@
// ----------------------------------------------------------------------------
// dpss_core
// Command state and step logic; state advances on i_step.
// ----------------------------------------------------------------------------
module dpss_core
    import dpss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_op               i_opcode,
    input  logic [WordW-1:0]  i_statusword,
    input  logic [WordW-1:0]  i_drive_error,
    input  logic [LimitW-1:0] i_attempt_limit,
    output t_result           o_result
);

    t_pstate           w_ps;
    t_op               r_act,   n_act;
    logic [LimitW-1:0] r_left,  n_left;
    logic [WordW-1:0]  r_held,  n_held;
    logic [WordW-1:0]  r_saved, n_saved;
    t_outcome          w_outc;
    logic              w_just_reset;
    logic              w_err_clear;

    dpss_decode u_decode (
        .i_statusword  (i_statusword),
        .o_power_state (w_ps)
    );

    assign w_err_clear = (i_drive_error == '0);

    always_comb begin
        n_act        = r_act;
        n_left       = r_left;
        n_held       = r_held;
        n_saved      = r_saved;
        w_outc       = OC_IDLE;
        w_just_reset = 1'b0;

        if (i_opcode != OP_TICK) begin
            // a running fault reset gives back the controlword it displaced
            if (r_act == OP_FAULT_RESET) n_held = r_saved;
            n_act  = i_opcode;
            n_left = i_attempt_limit;
            if (i_opcode == OP_FAULT_RESET) begin
                w_just_reset = 1'b1;
                if (w_err_clear) begin
                    n_act  = OP_TICK;
                    w_outc = OC_GOAL;
                end else begin
                    n_saved = n_held;
                    n_held  = CwFaultReset;
                    w_outc  = OC_BUSY;
                end
            end
        end

        unique case (n_act)
            OP_ENABLE: begin
                if (w_ps == PS_ENABLED) begin
                    n_act  = OP_TICK;
                    w_outc = OC_GOAL;
                end else if (n_left == '0) begin
                    n_act  = OP_TICK;
                    w_outc = OC_FAIL_LIM;
                end else if (w_ps == PS_SWITCH_DIS || w_ps == PS_READY
                             || w_ps == PS_SWITCHED_ON) begin
                    n_held = (w_ps == PS_SWITCH_DIS) ? CwShutdown :
                             (w_ps == PS_READY)      ? CwSwitchOn : CwEnableOp;
                    n_left = n_left - 1'b1;
                    w_outc = OC_BUSY;
                end else begin
                    n_act  = OP_TICK;
                    w_outc = OC_FAIL_STAT;
                end
            end
            OP_DISABLE: begin
                if (w_ps == PS_SWITCH_DIS || w_ps == PS_READY) begin
                    n_act  = OP_TICK;
                    w_outc = OC_GOAL;
                end else if (n_left == '0) begin
                    n_act  = OP_TICK;
                    w_outc = OC_FAIL_LIM;
                end else if (w_ps == PS_SWITCHED_ON || w_ps == PS_ENABLED) begin
                    n_held = (w_ps == PS_ENABLED) ? CwSwitchOn : CwShutdown;
                    n_left = n_left - 1'b1;
                    w_outc = OC_BUSY;
                end else begin
                    n_held = CwShutdown;
                    n_act  = OP_TICK;
                    w_outc = OC_FAIL_STAT;
                end
            end
            OP_FAULT_RESET: begin
                if (!w_just_reset) begin
                    if (w_err_clear) begin
                        n_held = r_saved;
                        n_act  = OP_TICK;
                        w_outc = OC_GOAL;
                    end else if (n_left == '0) begin
                        n_held = r_saved;
                        n_act  = OP_TICK;
                        w_outc = OC_FAIL_LIM;
                    end else begin
                        n_held = CwFaultReset;
                        n_left = n_left - 1'b1;
                        w_outc = OC_BUSY;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= OP_TICK;
            r_left  <= '0;
            r_held  <= '0;
            r_saved <= '0;
        end else if (i_step) begin
            r_act   <= n_act;
            r_left  <= n_left;
            r_held  <= n_held;
            r_saved <= n_saved;
        end
    end

    assign o_result.control_word = n_held;
    assign o_result.power_state  = w_ps;
    assign o_result.outcome      = w_outc;

endmodule

@@ src/drive_power_state_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// drive_power_state_sequencer_unit
// Drive power state sequencer: statusword in, controlword and status out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one process cycle's sample: tuser is the command
//   (tick, start enable, start disable, start fault reset), tdata holds the
//   statusword and the drive error code. m_axis returns one result per
//   sample: controlword, decoded power state and command outcome.
//   i_cfg_we / i_cfg_wdata write the attempt limit; write only while idle.
//   A sample passes the input register, then the step logic into the result
//   register, before its result is offered on m_axis.
//   Throughput: one sample per cycle while m_axis takes every result; the
//   command state updates together with the result register.
//   Reset clears both pipeline stages, the command state and the held
//   controlword, and loads the attempt limit with 10.
//   When m_axis stalls, the result register holds, one more sample waits in
//   the input register, and s_axis_tready then drops until the result is
//   taken.
// ----------------------------------------------------------------------------
module drive_power_state_sequencer_unit
    import dpss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LimitW-1:0] i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // statusword[15:0], drive_error[31:16]
    input  logic [1:0]        s_axis_tuser,   // opcode[1:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata    // control_word[15:0], power_state[19:16],
                                              // outcome[22:20], zero[23]
);

    logic [LimitW-1:0] r_limit;
    logic              r_in_valid;
    t_op               r_in_op;
    logic [WordW-1:0]  r_in_sw;
    logic [WordW-1:0]  r_in_err;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_result;
    logic              w_advance;
    logic              w_in_xfer;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= AttemptLimitReset;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_op  <= t_op'(s_axis_tuser);
            r_in_sw  <= s_axis_tdata[15:0];
            r_in_err <= s_axis_tdata[31:16];
        end
    end

    dpss_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_advance),
        .i_opcode        (r_in_op),
        .i_statusword    (r_in_sw),
        .i_drive_error   (r_in_err),
        .i_attempt_limit (r_limit),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.outcome, r_out.power_state, r_out.control_word};

endmodule

@@ src/dpss_checker.sv @@
// ----------------------------------------------------------------------------
// dpss_checker
// Port-level checks for the drive power state sequencer, bound to the top.
// ----------------------------------------------------------------------------
module dpss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // nothing offered in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a ready sink never back-pressures the source
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled with output ready");

    // outcome and power state stay within their codes
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[19:16] <= 4'd8) && (m_axis_tdata[22:20] <= 3'd4)
                          && !m_axis_tdata[23])
        else $error("result code out of range");

endmodule

bind drive_power_state_sequencer_unit dpss_checker u_dpss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/drive_power_state_sequencer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// drive_power_state_sequencer_unit_tb
// Self-checking bench for the drive power state sequencer. A directed table
// covers the decode extremes, every command, aborts, limit exhaustion and
// fault reset restore. Random command sequences follow, with walking
// statuswords, noise and stalls on both streams. Results are checked against
// the table's expectation or a cycle-free model of the command state.
// ----------------------------------------------------------------------------
module drive_power_state_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpss_pkg::*;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned LongHold   = 300;
    localparam int unsigned PhaseItems = 175;

    typedef enum logic {ROW_SAMPLE, ROW_LIMIT} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_op               op;
        logic [WordW-1:0]  sw;
        logic [WordW-1:0]  err;
        logic [LimitW-1:0] limit;
        logic              typed;
        t_result           want;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [LimitW-1:0] i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;   // statusword[15:0], drive_error[31:16]
    logic [1:0]        s_axis_tuser = '0;   // opcode[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;        // control_word[15:0], power_state[19:16],
                                            // outcome[22:20], zero[23]

    drive_power_state_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // sequencer model state
    t_op               run_cmd    = OP_TICK;
    logic [LimitW-1:0] tries_left = '0;
    logic [LimitW-1:0] limit_reg  = AttemptLimitReset;
    logic [WordW-1:0]  held_cw    = '0;
    logic [WordW-1:0]  saved_cw   = '0;

    t_result  pending_results[$];
    t_dir_row dir_tab[$];

    int unsigned err_count    = 0;
    int unsigned samples_sent = 0;
    int unsigned cmds_started = 0;
    int unsigned results_seen = 0;
    int unsigned outcome_seen [0:4];
    int unsigned cycles       = 0;
    bit          src_calm     = 1'b0;
    bit          snk_calm     = 1'b0;

    function automatic t_pstate decode_power(input logic [WordW-1:0] sw);
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
        a = sw & SwMaskA;
        b = sw & SwMaskB;
        if (a == SwNotReady)   return PS_NOT_READY;
        if (a == SwSwitchDis)  return PS_SWITCH_DIS;
        if (b == SwReady)      return PS_READY;
        if (b == SwSwitchedOn) return PS_SWITCHED_ON;
        if (b == SwEnabled)    return PS_ENABLED;
        if (b == SwQuickStop)  return PS_QUICK_STOP;
        if (a == SwFaultReact) return PS_FAULT_REACT;
        if (a == SwFault)      return PS_FAULT;
        return PS_UNKNOWN;
    endfunction

    // Advances the command state by one sample and returns the result.
    function automatic t_result step_sequencer(input t_op op, input logic [WordW-1:0] sw,
                                               input logic [WordW-1:0] err);
        t_pstate  ps;
        t_outcome oc;
        bit       fresh_reset;
        t_result  res;
        ps = decode_power(sw);
        oc = OC_IDLE;
        fresh_reset = 1'b0;
        if (op != OP_TICK) begin
            // a pending fault reset gives back the controlword it displaced
            if (run_cmd == OP_FAULT_RESET) held_cw = saved_cw;
            run_cmd = op;
            tries_left = limit_reg;
            if (op == OP_FAULT_RESET) begin
                fresh_reset = 1'b1;
                if (err == '0) begin
                    run_cmd = OP_TICK;
                    oc = OC_GOAL;
                end else begin
                    saved_cw = held_cw;
                    held_cw = CwFaultReset;
                    oc = OC_BUSY;
                end
            end
        end
        case (run_cmd)
            OP_ENABLE: begin
                if (ps == PS_ENABLED) begin
                    run_cmd = OP_TICK;
                    oc = OC_GOAL;
                end else if (tries_left == '0) begin
                    run_cmd = OP_TICK;
                    oc = OC_FAIL_LIM;
                end else if (ps == PS_SWITCH_DIS || ps == PS_READY || ps == PS_SWITCHED_ON) begin
                    held_cw = (ps == PS_SWITCH_DIS) ? CwShutdown :
                              (ps == PS_READY) ? CwSwitchOn : CwEnableOp;
                    tries_left = tries_left - 1'b1;
                    oc = OC_BUSY;
                end else begin
                    run_cmd = OP_TICK;
                    oc = OC_FAIL_STAT;
                end
            end
            OP_DISABLE: begin
                if (ps == PS_SWITCH_DIS || ps == PS_READY) begin
                    run_cmd = OP_TICK;
                    oc = OC_GOAL;
                end else if (tries_left == '0) begin
                    run_cmd = OP_TICK;
                    oc = OC_FAIL_LIM;
                end else if (ps == PS_SWITCHED_ON || ps == PS_ENABLED) begin
                    held_cw = (ps == PS_SWITCHED_ON) ? CwShutdown : CwSwitchOn;
                    tries_left = tries_left - 1'b1;
                    oc = OC_BUSY;
                end else begin
                    held_cw = CwShutdown;
                    run_cmd = OP_TICK;
                    oc = OC_FAIL_STAT;
                end
            end
            OP_FAULT_RESET: begin
                if (!fresh_reset) begin
                    if (err == '0 || tries_left == '0) begin
                        held_cw = saved_cw;
                        oc = (err == '0) ? OC_GOAL : OC_FAIL_LIM;
                        run_cmd = OP_TICK;
                    end else begin
                        held_cw = CwFaultReset;
                        tries_left = tries_left - 1'b1;
                        oc = OC_BUSY;
                    end
                end
            end
            default: ;
        endcase
        res.control_word = held_cw;
        res.power_state = ps;
        res.outcome = oc;
        return res;
    endfunction

    function automatic int draw_wait(input bit calm);
        if (calm) return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
    endfunction

    function automatic t_dir_row row(input t_op op, input logic [WordW-1:0] sw,
                                     input logic [WordW-1:0] err, input logic typed,
                                     input logic [WordW-1:0] cw, input t_pstate ps,
                                     input t_outcome oc);
        t_dir_row r;
        r.kind = ROW_SAMPLE;
        r.op = op;
        r.sw = sw;
        r.err = err;
        r.limit = '0;
        r.typed = typed;
        r.want.control_word = cw;
        r.want.power_state = ps;
        r.want.outcome = oc;
        return r;
    endfunction

    function automatic t_dir_row lim_row(input logic [LimitW-1:0] v);
        t_dir_row r;
        r = row(OP_TICK, '0, '0, 1'b0, '0, PS_NOT_READY, OC_IDLE);
        r.kind = ROW_LIMIT;
        r.limit = v;
        return r;
    endfunction

    // statusword for a given power state, bits outside the compare masks random
    function automatic logic [WordW-1:0] status_for(input t_pstate ps);
        logic [WordW-1:0] rnd;
        rnd = WordW'($urandom);
        case (ps)
            PS_NOT_READY:   return (rnd & ~SwMaskA) | SwNotReady;
            PS_SWITCH_DIS:  return (rnd & ~SwMaskA) | SwSwitchDis;
            PS_READY:       return (rnd & ~SwMaskB) | SwReady;
            PS_SWITCHED_ON: return (rnd & ~SwMaskB) | SwSwitchedOn;
            PS_ENABLED:     return (rnd & ~SwMaskB) | SwEnabled;
            PS_QUICK_STOP:  return (rnd & ~SwMaskB) | SwQuickStop;
            PS_FAULT_REACT: return (rnd & ~SwMaskA) | SwFaultReact;
            PS_FAULT:       return (rnd & ~SwMaskA) | SwFault;
            default: begin
                case ($urandom_range(0, 2))
                    0:       return (rnd & ~SwMaskB) | 16'h0001;
                    1:       return (rnd & ~SwMaskB) | 16'h0041;
                    default: return (rnd & ~SwMaskB) | 16'h004f;
                endcase
            end
        endcase
    endfunction

    // Offers one sample; called at a rising edge, returns at one.
    task automatic send_sample(input t_op op, input logic [WordW-1:0] sw,
                               input logic [WordW-1:0] err, input logic typed,
                               input t_result want);
        t_result predicted;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {err, sw};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predicted = step_sequencer(op, sw, err);
        pending_results.push_back(typed ? want : predicted);
        samples_sent++;
        if (op != OP_TICK) cmds_started++;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_predicted(input t_op op, input logic [WordW-1:0] sw,
                                  input logic [WordW-1:0] err);
        send_sample(op, sw, err, 1'b0, '0);
    endtask

    // Attempt limit is only written with the pipeline empty.
    task automatic write_limit(input logic [LimitW-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        limit_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_command_sequence();
        t_op cmd;
        t_op op;
        t_pstate ps;
        logic [WordW-1:0] err;
        int ticks;
        int r;
        cmd = t_op'($urandom_range(1, 3));
        err = '0;
        case (cmd)
            OP_ENABLE:  ps = t_pstate'($urandom_range(1, 4));
            OP_DISABLE: ps = t_pstate'($urandom_range(1, 4));
            default: begin
                ps = ($urandom_range(0, 3) == 0) ? PS_FAULT_REACT : PS_FAULT;
                if ($urandom_range(0, 5) != 0) err = WordW'($urandom_range(1, 16'hffff));
            end
        endcase
        send_predicted(cmd, status_for(ps), err);
        ticks = 0;
        while (run_cmd != OP_TICK && ticks < 40) begin
            r = $urandom_range(0, 99);
            if (r >= 94) begin
                ps = t_pstate'($urandom_range(0, 8));
            end else if (r < 60) begin
                case (cmd)
                    OP_ENABLE: ps = (ps >= PS_SWITCH_DIS && ps <= PS_SWITCHED_ON) ?
                                    t_pstate'(ps + 1) : PS_SWITCH_DIS;
                    OP_DISABLE: ps = (ps == PS_ENABLED) ? PS_SWITCHED_ON :
                                     (ps == PS_SWITCHED_ON) ? PS_READY : PS_SWITCHED_ON;
                    default: ps = (err == '0) ? PS_SWITCH_DIS : PS_FAULT;
                endcase
            end
            if (cmd == OP_FAULT_RESET && $urandom_range(0, 3) == 0) err = '0;
            // now and then a new command cuts in
            op = ($urandom_range(0, 39) == 0) ? t_op'($urandom_range(1, 3)) : OP_TICK;
            send_predicted(op, status_for(ps), err);
            ticks++;
        end
    endtask

    task automatic check_result(input logic [23:0] d);
        t_result want;
        if (pending_results.size() == 0) begin
            $error("result with nothing expected: %h", d);
            err_count++;
        end else begin
            want = pending_results.pop_front();
            outcome_seen[want.outcome]++;
            if (d[15:0] !== want.control_word) begin
                $error("control_word mismatch: expected %h, got %h", want.control_word,
                       d[15:0]);
                err_count++;
            end
            if (d[19:16] !== want.power_state) begin
                $error("power_state mismatch: expected %0d, got %0d", want.power_state,
                       d[19:16]);
                err_count++;
            end
            if (d[22:20] !== want.outcome) begin
                $error("outcome mismatch: expected %0d, got %0d", want.outcome, d[22:20]);
                err_count++;
            end
        end
        results_seen++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result sink: random back-pressure, twice a long hold to fill the pipe
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(snk_calm);
            if (results_seen == 150 || results_seen == 600) stall = LongHold;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1 || m_axis_tready !== 1'b1);
            check_result(m_axis_tdata);
        end
    end

    initial begin : stimulus
        int ph;
        int unsigned target;
        logic [LimitW-1:0] lim;
        t_op op;

        foreach (outcome_seen[k]) outcome_seen[k] = 0;

        // decode extremes, idle ticks
        dir_tab.push_back(row(OP_TICK, 16'h0000, 16'h0000, 1, 16'h0000, PS_NOT_READY, OC_IDLE));
        dir_tab.push_back(row(OP_TICK, 16'hffff, 16'hffff, 1, 16'h0000, PS_UNKNOWN, OC_IDLE));
        // full enable walk
        dir_tab.push_back(row(OP_ENABLE, 16'h0040, 16'h0000, 1, CwShutdown, PS_SWITCH_DIS,
                              OC_BUSY));
        dir_tab.push_back(row(OP_TICK, 16'h0021, 16'h0000, 1, CwSwitchOn, PS_READY, OC_BUSY));
        dir_tab.push_back(row(OP_TICK, 16'h0023, 16'h0000, 1, CwEnableOp, PS_SWITCHED_ON,
                              OC_BUSY));
        dir_tab.push_back(row(OP_TICK, 16'h0027, 16'h0000, 1, CwEnableOp, PS_ENABLED, OC_GOAL));
        // disable walk
        dir_tab.push_back(row(OP_DISABLE, 16'h0027, 16'h0000, 1, CwSwitchOn, PS_ENABLED,
                              OC_BUSY));
        dir_tab.push_back(row(OP_TICK, 16'h0023, 16'h0000, 1, CwShutdown, PS_SWITCHED_ON,
                              OC_BUSY));
        dir_tab.push_back(row(OP_TICK, 16'h0021, 16'h0000, 1, CwShutdown, PS_READY, OC_GOAL));
        // fault reset with no error finishes at once
        dir_tab.push_back(row(OP_FAULT_RESET, 16'h0008, 16'h0000, 1, CwShutdown, PS_FAULT,
                              OC_GOAL));
        dir_tab.push_back(row(OP_FAULT_RESET, 16'h0008, 16'h1234, 0, '0, PS_FAULT, OC_IDLE));
        dir_tab.push_back(row(OP_TICK, 16'h000f, 16'h1234, 0, '0, PS_FAULT, OC_IDLE));
        dir_tab.push_back(row(OP_TICK, 16'h0040, 16'h0000, 0, '0, PS_FAULT, OC_IDLE));
        // enable cutting into a fault reset restores the saved controlword
        dir_tab.push_back(row(OP_FAULT_RESET, 16'h0008, 16'hffff, 0, '0, PS_FAULT, OC_IDLE));
        dir_tab.push_back(row(OP_ENABLE, 16'h0040, 16'hffff, 0, '0, PS_FAULT, OC_IDLE));
        // aborts on unexpected states, then an enable that meets its goal at once
        dir_tab.push_back(row(OP_TICK, 16'h000f, 16'h0000, 1, CwShutdown, PS_FAULT_REACT,
                              OC_FAIL_STAT));
        dir_tab.push_back(row(OP_DISABLE, 16'h0008, 16'h0000, 1, CwShutdown, PS_FAULT,
                              OC_FAIL_STAT));
        dir_tab.push_back(row(OP_DISABLE, 16'h0007, 16'h0000, 1, CwShutdown, PS_QUICK_STOP,
                              OC_FAIL_STAT));
        dir_tab.push_back(row(OP_ENABLE, 16'h0027, 16'h0000, 1, CwShutdown, PS_ENABLED,
                              OC_GOAL));
        // no attempts allowed
        dir_tab.push_back(lim_row(8'd0));
        dir_tab.push_back(row(OP_ENABLE, 16'h0040, 16'h0000, 1, CwShutdown, PS_SWITCH_DIS,
                              OC_FAIL_LIM));
        dir_tab.push_back(row(OP_DISABLE, 16'h0023, 16'h0000, 1, CwShutdown, PS_SWITCHED_ON,
                              OC_FAIL_LIM));
        dir_tab.push_back(row(OP_FAULT_RESET, 16'h0008, 16'h0001, 0, '0, PS_FAULT, OC_IDLE));
        dir_tab.push_back(row(OP_TICK, 16'h0008, 16'h0001, 1, CwShutdown, PS_FAULT,
                              OC_FAIL_LIM));
        // two attempts, drive never moves
        dir_tab.push_back(lim_row(8'd2));
        dir_tab.push_back(row(OP_ENABLE, 16'h0040, 16'h0000, 0, '0, PS_FAULT, OC_IDLE));
        dir_tab.push_back(row(OP_TICK, 16'h0040, 16'h0000, 0, '0, PS_FAULT, OC_IDLE));
        dir_tab.push_back(row(OP_TICK, 16'h0040, 16'h0000, 1, CwShutdown, PS_SWITCH_DIS,
                              OC_FAIL_LIM));
        dir_tab.push_back(row(OP_TICK, 16'hffb0, 16'h0000, 1, CwShutdown, PS_NOT_READY,
                              OC_IDLE));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_LIMIT)
                write_limit(dir_tab[i].limit);
            else
                send_sample(dir_tab[i].op, dir_tab[i].sw, dir_tab[i].err, dir_tab[i].typed,
                            dir_tab[i].want);
        end

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       lim = 8'd3;
                1:       lim = 8'd255;
                2:       lim = 8'd0;
                3:       lim = 8'd1;
                4:       lim = LimitW'($urandom_range(2, 254));
                default: lim = AttemptLimitReset;
            endcase
            write_limit(lim);
            src_calm = (ph == 2);
            snk_calm = (ph == 4);
            target = samples_sent + PhaseItems;
            while (samples_sent < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    op = ($urandom_range(0, 3) == 0) ? t_op'($urandom_range(0, 3)) : OP_TICK;
                    send_predicted(op, WordW'($urandom),
                                   ($urandom_range(0, 1) == 0) ? '0 : WordW'($urandom));
                end else begin
                    run_command_sequence();
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run: %0d samples, %0d commands started, %0d results checked.",
                 samples_sent, cmds_started, results_seen);
        $display("Outcomes: idle %0d, busy %0d, goal %0d, limit fail %0d, state fail %0d.",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
                 outcome_seen[4]);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
src/dpss_pkg.sv
src/dpss_decode.sv
src/dpss_core.sv
src/drive_power_state_sequencer_unit.sv
src/dpss_checker.sv
tb/drive_power_state_sequencer_unit_tb.sv
